/* rtl/lru_handle_cache_top_assert.svh */
// Assertion macros used by the cache datapath.
`ifndef LRU_HANDLE_CACHE_TOP_ASSERT_SVH
`define LRU_HANDLE_CACHE_TOP_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define LHC_ASSERT_NOW(lbl, ck, rs, ante, cons, msg) \
  lbl: assert property (@(posedge ck) disable iff (rs) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, checked outside reset.
`define LHC_ASSERT_NEXT(lbl, ck, rs, ante, cons, msg) \
  lbl: assert property (@(posedge ck) disable iff (rs) (ante) |=> (cons)) else $error(msg);

`endif

/* rtl/lhc_pkg.sv */
package lhc_pkg;

  // Default number of cache slots
  localparam int ENTRIES_DEF = 8;
  // Fixed field widths
  localparam int ID_W   = 32;
  localparam int SLOT_W = 3;

  // Commands from the controller to the datapath
  typedef struct packed {
    logic load;    // capture the request id
    logic commit;  // look up, update the store and load the result register
  } lhc_cmd_t;

endpackage

/* rtl/lhc_ctrl.sv */
module lhc_ctrl
  import lhc_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  logic     req_valid,
  output logic     req_ready,
  output logic     rsp_valid,
  input  logic     rsp_ready,
  output lhc_cmd_t cmd
);

  typedef enum logic {
    S_IDLE,
    S_LOOK
  } state_t;

  state_t state;

  // Commands
  assign cmd.load   = req_valid && req_ready;
  assign cmd.commit = (state == S_LOOK) && (!rsp_valid || rsp_ready);

  // State and registered handshake outputs
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      req_ready <= 1'b1;
      rsp_valid <= 1'b0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (rsp_valid && rsp_ready) begin
            rsp_valid <= 1'b0;
          end
          if (cmd.load) begin
            state     <= S_LOOK;
            req_ready <= 1'b0;
          end
        end
        S_LOOK: begin
          // result register must be empty or draining before the commit
          if (cmd.commit) begin
            state     <= S_IDLE;
            req_ready <= 1'b1;
            rsp_valid <= 1'b1;
          end
        end
        default: begin
          state     <= S_IDLE;
          req_ready <= 1'b1;
        end
      endcase
    end
  end

endmodule

/* rtl/lhc_dp.sv */
`include "lru_handle_cache_top_assert.svh"

module lhc_dp
  import lhc_pkg::*;
#(
  parameter int ENTRIES = ENTRIES_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  lhc_cmd_t          cmd,
  input  logic [ID_W-1:0]   request_id,
  output logic              hit,
  output logic [SLOT_W-1:0] slot,
  output logic              evicted,
  output logic [ID_W-1:0]   evicted_id
);

  localparam int IW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam logic [IW-1:0] AGE_OLDEST = IW'(ENTRIES - 1);

  // Slot store
  logic [ID_W-1:0] tag   [ENTRIES];
  logic [ENTRIES-1:0] valid;
  logic [IW-1:0]   age   [ENTRIES];

  logic [ID_W-1:0] req_id_q;
  logic [IW-1:0]   slot_q;

  // Lookup results
  logic          hit_any;
  logic [IW-1:0] hit_idx;
  logic          have_free;
  logic [IW-1:0] free_idx;
  logic [IW-1:0] vic_idx;
  logic [IW-1:0] sel_idx;
  logic          do_evict;
  logic [IW-1:0] sel_age;

  // Parallel tag compare, free-slot and victim search, lowest slot first
  always_comb begin
    hit_any   = 1'b0;
    hit_idx   = '0;
    have_free = 1'b0;
    free_idx  = '0;
    vic_idx   = '0;
    for (int i = ENTRIES - 1; i >= 0; i--) begin
      if (valid[i] && (tag[i] == req_id_q)) begin
        hit_any = 1'b1;
        hit_idx = IW'(i);
      end
      if (!valid[i]) begin
        have_free = 1'b1;
        free_idx  = IW'(i);
      end
      // ages are a permutation of ranks when full, so the oldest is unique
      if (age[i] == AGE_OLDEST) begin
        vic_idx = IW'(i);
      end
    end
  end

  assign do_evict = !hit_any && !have_free;
  assign sel_idx  = hit_any ? hit_idx : (have_free ? free_idx : vic_idx);
  assign sel_age  = age[hit_idx];

  // Request capture
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      req_id_q <= request_id;
    end
  end

  // Recency and valid update
  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
      for (int i = 0; i < ENTRIES; i++) begin
        age[i] <= '0;
      end
    end else if (cmd.commit) begin
      valid[sel_idx] <= 1'b1;
      for (int i = 0; i < ENTRIES; i++) begin
        if (IW'(i) == sel_idx) begin
          age[i] <= '0;
        end else if (valid[i] && (!hit_any || (age[i] < sel_age))) begin
          age[i] <= age[i] + 1'b1;
        end
      end
    end
  end

  // Tag write on a miss; result register
  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      if (!hit_any) begin
        tag[sel_idx] <= req_id_q;
      end
      hit        <= hit_any;
      slot_q     <= sel_idx;
      evicted    <= do_evict;
      evicted_id <= do_evict ? tag[vic_idx] : '0;
    end
  end

  assign slot = SLOT_W'(slot_q);

  // Checks
  `LHC_ASSERT_NEXT(a_slot_holds_id, clk, rst, cmd.commit,
    valid[slot_q] && (tag[slot_q] == $past(req_id_q)), "slot does not hold the request id")
  `LHC_ASSERT_NOW(a_evict_only_full, clk, rst, cmd.commit && do_evict,
    &valid, "eviction while a slot is free")
  `LHC_ASSERT_NEXT(a_valid_grows, clk, rst, cmd.commit,
    $countones(valid) >= $countones($past(valid)), "valid slot count fell")
  `LHC_ASSERT_NEXT(a_hit_no_evict, clk, rst, cmd.commit,
    !(hit && evicted), "hit reported together with an eviction")

endmodule

/* rtl/lru_handle_cache_top.sv */
// Channel   Handshake                Beat fields
// request   req_valid / req_ready    request_id
// response  rsp_valid / rsp_ready    hit, slot, evicted, evicted_id
//
// Each request passes two steps: capture of the id, then the
// parallel tag compare and recency update of all slots.
// A new request is taken while the previous response still waits.
// The update cycle holds while a full response register is not drained.
// Synchronous reset empties every slot; no clearing pass is needed.
module lru_handle_cache_top
  import lhc_pkg::*;
#(
  parameter int ENTRIES = ENTRIES_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              req_valid,
  output logic              req_ready,
  input  logic [ID_W-1:0]   request_id,
  output logic              rsp_valid,
  input  logic              rsp_ready,
  output logic              hit,
  output logic [SLOT_W-1:0] slot,
  output logic              evicted,
  output logic [ID_W-1:0]   evicted_id
);

  lhc_cmd_t cmd;

  lhc_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .cmd       (cmd)
  );

  lhc_dp #(
    .ENTRIES (ENTRIES)
  ) u_dp (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .request_id (request_id),
    .hit        (hit),
    .slot       (slot),
    .evicted    (evicted),
    .evicted_id (evicted_id)
  );

endmodule

/* sim/tb_lru_handle_cache_top.sv */
`timescale 1ns / 1ps

module tb_lru_handle_cache_top
  import lhc_pkg::*;
;

  localparam int ENTRIES   = ENTRIES_DEF;
  localparam int HOLD_LEN  = 64;  // cycles of response hold-off in the stall test
  localparam int RAND_LEN  = 250; // requests per idle profile

  // One response beat as the cache should produce it
  typedef struct packed {
    logic              hit;
    logic [SLOT_W-1:0] slot;
    logic              evicted;
    logic [ID_W-1:0]   evicted_id;
  } lookup_rsp_t;

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              req_valid = 1'b0;
  logic              req_ready;
  logic [ID_W-1:0]   request_id = '0;
  logic              rsp_valid;
  logic              rsp_ready = 1'b0;
  logic              hit;
  logic [SLOT_W-1:0] slot;
  logic              evicted;
  logic [ID_W-1:0]   evicted_id;

  // Shadow copy of the cache contents
  logic [ID_W-1:0] shadow_tag   [ENTRIES];
  logic            shadow_valid [ENTRIES] = '{default: 1'b0};
  int              shadow_rank  [ENTRIES] = '{default: 0};

  lookup_rsp_t     expected_rsp[$];
  logic [ID_W-1:0] id_pool[$];

  int   send_idle_pct = 0;
  int   rsp_stall_pct = 0;
  logic rsp_hold      = 1'b0;
  int   sent_count    = 0;
  int   checked_count = 0;
  int   hit_count     = 0;
  int   evict_count   = 0;
  int   err_count     = 0;

  always #2 clk = ~clk;

  lru_handle_cache_top #(
    .ENTRIES(ENTRIES)
  ) i_dut (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .request_id(request_id),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .hit       (hit),
    .slot      (slot),
    .evicted   (evicted),
    .evicted_id(evicted_id)
  );

  // Move slot s to the front; valid slots more recent than limit age by one
  function automatic void promote_slot(int s, int limit);
    for (int i = 0; i < ENTRIES; i++) begin
      if (shadow_valid[i] && i != s && shadow_rank[i] < limit)
        shadow_rank[i]++;
    end
    shadow_rank[s] = 0;
  endfunction

  // Look an id up in the shadow cache, update it and return the expected beat
  function automatic lookup_rsp_t lookup_and_update(logic [ID_W-1:0] id);
    lookup_rsp_t r;
    int  s;
    int  free_s;
    bit  found;
    bit  have_free;
    r         = '0;
    s         = 0;
    free_s    = 0;
    found     = 0;
    have_free = 0;
    for (int i = 0; i < ENTRIES; i++) begin
      if (shadow_valid[i] && shadow_tag[i] == id && !found) begin
        found = 1;
        s     = i;
      end
      if (!shadow_valid[i] && !have_free) begin
        have_free = 1;
        free_s    = i;
      end
    end
    if (found) begin
      promote_slot(s, shadow_rank[s]);
    end else if (have_free) begin
      s               = free_s;
      shadow_tag[s]   = id;
      shadow_valid[s] = 1'b1;
      promote_slot(s, 255);
    end else begin
      // victim is the oldest slot, lowest index on a tie
      s = 0;
      for (int i = 1; i < ENTRIES; i++)
        if (shadow_rank[i] > shadow_rank[s]) s = i;
      r.evicted    = 1'b1;
      r.evicted_id = shadow_tag[s];
      shadow_tag[s] = id;
      promote_slot(s, 255);
    end
    r.hit  = found;
    r.slot = s[SLOT_W-1:0];
    return r;
  endfunction

  // Offer one request beat, with random idle cycles ahead of it
  task automatic send_request(input logic [ID_W-1:0] id);
    lookup_rsp_t r;
    while ($urandom_range(99) < send_idle_pct) begin
      req_valid <= 1'b0;
      @(posedge clk);
    end
    req_valid  <= 1'b1;
    request_id <= id;
    do @(posedge clk); while (!req_ready);
    r = lookup_and_update(id);
    expected_rsp.push_back(r);
    if (r.hit) hit_count++;
    if (r.evicted) evict_count++;
    sent_count++;
  endtask

  // Drop valid and let every outstanding response come back
  task automatic drain();
    req_valid <= 1'b0;
    while (expected_rsp.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  function automatic logic [ID_W-1:0] pick_id();
    if ($urandom_range(99) < 12 || id_pool.size() == 0)
      return $urandom;
    return id_pool[$urandom_range(id_pool.size() - 1)];
  endfunction

  // Extreme ids, fill from empty, hits on newest and oldest, evictions
  task automatic test_fill_and_evict();
    logic [ID_W-1:0] ids[$];
    send_idle_pct = 0;
    rsp_stall_pct <= 0;
    ids = {32'h0000_0000, 32'hFFFF_FFFF, 32'h0000_0000, 32'h0000_0000,
           32'hA5A5_A5A5, 32'h5A5A_5A5A, 32'h0000_0001, 32'h8000_0000,
           32'h1234_5678, 32'hDEAD_BEEF, 32'hCAFE_F00D, 32'h0000_0001,
           32'h0000_0007, 32'hFFFF_FFFF, 32'hDEAD_BEEF, 32'h7FFF_FFFF,
           32'h0000_0000, 32'hFFFF_FFFE};
    foreach (ids[i]) send_request(ids[i]);
    drain();
  endtask

  // Random ids drawn mostly from a small working set, so hits and
  // evictions both come up often
  task automatic test_random_mix(input int n, input int idle_pct, input int stall_pct);
    send_idle_pct = idle_pct;
    rsp_stall_pct <= stall_pct;
    id_pool.delete();
    repeat ($urandom_range(14, 6)) id_pool.push_back($urandom);
    for (int i = 0; i < n; i++) begin
      // refresh part of the working set now and then
      if (i % 50 == 49) id_pool[$urandom_range(id_pool.size() - 1)] = $urandom;
      send_request(pick_id());
    end
    drain();
  endtask

  // Long response hold-off while requests keep coming, so the input backs up
  task automatic test_output_stall();
    send_idle_pct = 0;
    rsp_stall_pct <= 0;
    fork
      begin
        rsp_hold <= 1'b1;
        repeat (HOLD_LEN) @(posedge clk);
        rsp_hold <= 1'b0;
      end
    join_none
    repeat (30) send_request(pick_id());
    drain();
  endtask

  // Response ready: random stalls, or held low during a hold-off
  always @(posedge clk) begin
    if (rsp_hold)
      rsp_ready <= 1'b0;
    else
      rsp_ready <= ($urandom_range(99) >= rsp_stall_pct);
  end

  // Compare each response beat with the oldest prediction
  always @(posedge clk) begin
    lookup_rsp_t want;
    if (!rst && rsp_valid && rsp_ready) begin
      if (expected_rsp.size() == 0) begin
        $error("response beat with no request outstanding");
        err_count++;
      end else begin
        want = expected_rsp[0];
        expected_rsp.delete(0);
        if (hit !== want.hit) begin
          $error("hit: expected %0d, got %0d", want.hit, hit);
          err_count++;
        end
        if (slot !== want.slot) begin
          $error("slot: expected %0d, got %0d", want.slot, slot);
          err_count++;
        end
        if (evicted !== want.evicted) begin
          $error("evicted: expected %0d, got %0d", want.evicted, evicted);
          err_count++;
        end
        if (evicted_id !== want.evicted_id) begin
          $error("evicted_id: expected %h, got %h", want.evicted_id, evicted_id);
          err_count++;
        end
        checked_count++;
      end
    end
  end

  initial begin
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_fill_and_evict();
    test_random_mix(RAND_LEN, 0, 0);
    test_random_mix(RAND_LEN, 62, 0);
    test_random_mix(RAND_LEN, 0, 62);
    test_random_mix(RAND_LEN, 30, 30);
    test_output_stall();
    $display("%0d requests sent, %0d responses checked (%0d hits, %0d evictions)",
             sent_count, checked_count, hit_count, evict_count);
    $display("covered: fill from empty, extreme ids, four idle profiles, long output stall");
    if (err_count == 0)
      $display("lru_handle_cache_top: match");
    else
      $display("lru_handle_cache_top: mismatch");
    $finish;
  end

  // Watchdog
  initial begin
    #2000000;
    $display("lru_handle_cache_top: mismatch");
    $finish;
  end

endmodule

/* filelist.f */
+incdir+rtl
rtl/lhc_pkg.sv
rtl/lhc_ctrl.sv
rtl/lhc_dp.sv
rtl/lru_handle_cache_top.sv
sim/tb_lru_handle_cache_top.sv
